>>> design/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants of the best-fit page bitmap allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

   localparam int NUM_PAGES = 1024;
   localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
   localparam int PAGE_W    = $clog2(NUM_PAGES + 1);
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WORD_W + 5;
   localparam int MAX_SHIFT = 20;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_SHIFT = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_RANGE = 2'd2,
      ST_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic        action;
      logic [31:0] address;
      logic [30:0] length_bytes;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [32:0] block_address;
      logic [30:0] largest_free_bytes;
   } rsp_type;

   // effective configuration, already clamped
   typedef struct packed {
      logic [31:0]       base;
      logic [4:0]        shift;
      logic [PAGE_W-1:0] usable;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type      kind;
      status_type        status;
      logic [PAGE_W-1:0] need;
      logic [PAGE_W-1:0] lo;
      logic [PAGE_W-1:0] hi;
   } cmd_type;

endpackage

>>> design/best_fit_page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_page_bitmap_allocator
// Best-fit page allocator over a used/free bitmap held in a small RAM.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full and each gives exactly one result
// on rsp_empty/rsp_pop, in order. Registers are written on the csr_ channel,
// which is always ready; write them only while no request is in flight.
// The front rounds the length to pages and range-checks frees, then hands a
// command through a two-entry queue to the back.
// The back works one item at a time. A bitmap scan reads each map word,
// captures it and processes it in four steps of eight pages, then closes;
// marking reads and writes each word touched. A successful allocate takes
// two scans plus marking, a failed one two scans, a free one scan plus
// marking, an error item one scan.
// Reset frees every page at once through per-word valid bits and empties
// both sides. A stalled receiver holds the result register; the back then
// waits with its finished item and the front takes items until it and the queue fill.
// ----------------------------------------------------------------------------
module best_fit_page_bitmap_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bfpa_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bfpa_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import bfpa_pkg::*;

   logic [31:0] base_ff, base_in;
   logic [4:0]  shift_ff, shift_in;
   logic [10:0] count_ff, count_in;
   cfg_type     cfg;
   logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type     cmd_in_item, cmd_out_item;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in  = base_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE:  base_in  = csr_data;
            CSR_SHIFT: shift_in = csr_data[4:0];
            CSR_COUNT: count_in = csr_data[10:0];
            default:   base_in  = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 32'd0;
         shift_ff <= 5'd12;
         count_ff <= 11'd1024;
      end else begin
         base_ff  <= base_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      cfg.base   = base_ff;
      cfg.shift  = (shift_ff > 5'(MAX_SHIFT)) ? 5'(MAX_SHIFT) : shift_ff;
      cfg.usable = (32'(count_ff) > 32'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                    : PAGE_W'(count_ff);
   end

   bfpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_item (cmd_in_item)
   );

   bfpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_item (cmd_in_item),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_item  (cmd_out_item)
   );

   bfpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_out_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

>>> design/bfpa_ram.sv
// ----------------------------------------------------------------------------
// bfpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/bfpa_front.sv
// ----------------------------------------------------------------------------
// bfpa_front
// Accepts request items, rounds lengths to pages and range-checks frees.
// ----------------------------------------------------------------------------
module bfpa_front (
   input  logic               clock,
   input  logic               reset,
   input  bfpa_pkg::cfg_type  cfg,
   input  logic               req_push,
   output logic               req_full,
   input  bfpa_pkg::req_type  req_item,
   output logic               cmd_push,
   input  logic               cmd_full,
   output bfpa_pkg::cmd_type  cmd_item
);
   import bfpa_pkg::*;

   logic        busy_ff, busy_in;
   logic        action_ff;
   logic        zero_ff;
   logic        below_ff;
   logic [31:0] pages_ff;
   logic [31:0] off_ff;

   logic        accept;
   logic [31:0] round_sum;
   logic [31:0] first;
   logic [32:0] span_end;

   assign req_full  = busy_ff;
   assign accept    = req_push && !busy_ff;
   assign round_sum = {1'b0, req_item.length_bytes} + ((32'd1 << cfg.shift) - 32'd1);
   assign cmd_push  = busy_ff && !cmd_full;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (cmd_push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_item.action;
         zero_ff   <= (req_item.length_bytes == 31'd0);
         below_ff  <= (req_item.address < cfg.base);
         pages_ff  <= round_sum >> cfg.shift;
         off_ff    <= req_item.address - cfg.base;
      end
   end

   assign first    = off_ff >> cfg.shift;
   assign span_end = {1'b0, first} + {1'b0, pages_ff};

   always_comb begin
      cmd_item.kind   = CMD_NONE;
      cmd_item.status = ST_OK;
      cmd_item.need   = '0;
      cmd_item.lo     = first[PAGE_W-1:0];
      cmd_item.hi     = span_end[PAGE_W-1:0];
      if (pages_ff > 32'(NUM_PAGES)) begin
         cmd_item.need = PAGE_W'(NUM_PAGES + 1);
      end else begin
         cmd_item.need = pages_ff[PAGE_W-1:0];
      end
      if (zero_ff) begin
         cmd_item.status = ST_ZERO;
      end else if (action_ff == ACT_ALLOC) begin
         cmd_item.kind = CMD_ALLOC;
      end else if (below_ff || (span_end > 33'(cfg.usable))) begin
         cmd_item.status = ST_RANGE;
      end else begin
         cmd_item.kind = CMD_FREE;
      end
   end

endmodule

>>> design/bfpa_queue.sv
// ----------------------------------------------------------------------------
// bfpa_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bfpa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  bfpa_pkg::cmd_type  push_item,
   input  logic               pop,
   output logic               empty,
   output bfpa_pkg::cmd_type  pop_item
);
   import bfpa_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

endmodule

>>> design/bfpa_back.sv
// ----------------------------------------------------------------------------
// bfpa_back
// Scans the page bitmap for runs, marks or clears pages, forms the result.
// ----------------------------------------------------------------------------
module bfpa_back (
   input  logic               clock,
   input  logic               reset,
   input  bfpa_pkg::cfg_type  cfg,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  bfpa_pkg::cmd_type  cmd_item,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output bfpa_pkg::rsp_type  rsp_item
);
   import bfpa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SRD   = 8'b0000_0010,
      S_SWT   = 8'b0000_0100,
      S_SPROC = 8'b0000_1000,
      S_CLOSE = 8'b0001_0000,
      S_MRD   = 8'b0010_0000,
      S_MWR   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] wcnt_ff, wcnt_in;
   logic [1:0]        bcnt_ff, bcnt_in;
   logic              fit_mode_ff, fit_mode_in;
   logic              set_mode_ff, set_mode_in;
   logic [WORD_W-1:0] wlast_ff, wlast_in;
   logic [31:0]       free_ff, free_in;
   logic [PAGE_W-1:0] run_ff, run_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [PAGE_W-1:0] largest_ff, largest_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [PAGE_W-1:0] best_ff, best_in;
   logic [PAGE_W-1:0] need_ff, need_in;
   logic [PAGE_W-1:0] lo_ff, lo_in;
   logic [PAGE_W-1:0] hi_ff, hi_in;
   cmd_kind_type      kind_ff, kind_in;
   status_type        status_ff, status_in;
   logic [MAP_WORDS-1:0] row_valid_ff, row_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic [31:0]       wr_data;
   logic [31:0]       rd_data;
   logic [31:0]       word;
   logic [31:0]       scan_free;
   logic [31:0]       mark_mask;
   logic [PAGE_W-1:0] s_run, s_largest, s_best;
   logic [IDX_W-1:0]  s_start, s_pos;
   logic              s_found;
   logic              rsp_load;
   logic [PAGE_W-1:0] hi_last;

   bfpa_ram #(
      .WIDTH (32),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wcnt_ff),
      .wr_data (wr_data),
      .rd_addr (wcnt_ff),
      .rd_data (rd_data)
   );

   // rows never written read as all free
   assign word = row_valid_ff[wcnt_ff] ? rd_data : 32'd0;

   always_comb begin
      logic [PAGE_W-1:0] pg;
      for (int i = 0; i < 32; i++) begin
         pg           = PAGE_W'({wcnt_ff, 5'(i)});
         scan_free[i] = !word[i] && (pg < cfg.usable);
         mark_mask[i] = (pg >= lo_ff) && (pg < hi_ff);
      end
   end

   assign wr_en   = (state_ff == S_MWR);
   assign wr_data = set_mode_ff ? (word | mark_mask) : (word & ~mark_mask);

   // eight pages of run tracking per cycle; the close step sees all used
   always_comb begin
      logic              bit_free;
      logic [PAGE_W-1:0] left;
      s_run     = run_ff;
      s_start   = start_ff;
      s_largest = largest_ff;
      s_found   = found_ff;
      s_pos     = pos_ff;
      s_best    = best_ff;
      for (int j = 0; j < 8; j++) begin
         bit_free = (state_ff == S_SPROC) && free_ff[{bcnt_ff, 3'(j)}];
         left     = s_run - need_ff;
         if (bit_free) begin
            if (s_run == '0) begin
               s_start = {wcnt_ff, bcnt_ff, 3'(j)};
            end
            s_run = s_run + 1'b1;
         end else if (s_run != '0) begin
            if (s_run > s_largest) begin
               s_largest = s_run;
            end
            if (fit_mode_ff && (s_run >= need_ff)) begin
               if (!s_found || (left < s_best)) begin
                  s_best  = left;
                  s_found = 1'b1;
                  s_pos   = s_start;
               end
            end
            s_run = '0;
         end
      end
   end

   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_pop);
   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;
   assign hi_last   = cmd_item.hi - 1'b1;

   always_comb begin
      state_in     = state_ff;
      wcnt_in      = wcnt_ff;
      bcnt_in      = bcnt_ff;
      fit_mode_in  = fit_mode_ff;
      set_mode_in  = set_mode_ff;
      wlast_in     = wlast_ff;
      free_in      = free_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      largest_in   = largest_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      need_in      = need_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               kind_in    = cmd_item.kind;
               status_in  = cmd_item.status;
               need_in    = cmd_item.need;
               lo_in      = cmd_item.lo;
               hi_in      = cmd_item.hi;
               found_in   = 1'b0;
               run_in     = '0;
               largest_in = '0;
               bcnt_in    = 2'd0;
               if (cmd_item.kind == CMD_FREE) begin
                  set_mode_in = 1'b0;
                  wcnt_in     = cmd_item.lo[IDX_W-1:5];
                  wlast_in    = hi_last[IDX_W-1:5];
                  state_in    = S_MRD;
               end else begin
                  fit_mode_in = (cmd_item.kind == CMD_ALLOC);
                  wcnt_in     = '0;
                  state_in    = S_SRD;
               end
            end
         end
         S_SRD: begin
            state_in = S_SWT;
         end
         S_SWT: begin
            free_in  = scan_free;
            bcnt_in  = 2'd0;
            state_in = S_SPROC;
         end
         S_SPROC: begin
            run_in     = s_run;
            start_in   = s_start;
            largest_in = s_largest;
            found_in   = s_found;
            pos_in     = s_pos;
            best_in    = s_best;
            bcnt_in    = bcnt_ff + 2'd1;
            if (bcnt_ff == 2'd3) begin
               if (wcnt_ff == WORD_W'(MAP_WORDS - 1)) begin
                  state_in = S_CLOSE;
               end else begin
                  wcnt_in  = wcnt_ff + 1'b1;
                  state_in = S_SRD;
               end
            end
         end
         S_CLOSE: begin
            largest_in = s_largest;
            found_in   = s_found;
            pos_in     = s_pos;
            best_in    = s_best;
            run_in     = '0;
            if (!fit_mode_ff) begin
               state_in = S_OUT;
            end else if (s_found) begin
               fit_mode_in = 1'b0;
               set_mode_in = 1'b1;
               lo_in       = PAGE_W'(s_pos);
               hi_in       = PAGE_W'(s_pos) + need_ff;
               wcnt_in     = s_pos[IDX_W-1:5];
               wlast_in    = WORD_W'((PAGE_W'(s_pos) + need_ff - 1'b1) >> 5);
               state_in    = S_MRD;
            end else begin
               fit_mode_in = 1'b0;
               status_in   = ST_NOFIT;
               largest_in  = '0;
               wcnt_in     = '0;
               bcnt_in     = 2'd0;
               state_in    = S_SRD;
            end
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            row_valid_in[wcnt_ff] = 1'b1;
            if (wcnt_ff == wlast_ff) begin
               fit_mode_in = 1'b0;
               largest_in  = '0;
               run_in      = '0;
               wcnt_in     = '0;
               bcnt_in     = 2'd0;
               state_in    = S_SRD;
            end else begin
               wcnt_in  = wcnt_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wcnt_ff     <= wcnt_in;
      bcnt_ff     <= bcnt_in;
      fit_mode_ff <= fit_mode_in;
      set_mode_ff <= set_mode_in;
      wlast_ff    <= wlast_in;
      free_ff     <= free_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      largest_ff  <= largest_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      best_ff     <= best_in;
      need_ff     <= need_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      kind_ff     <= kind_in;
      status_ff   <= status_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.status <= status_ff;
         if ((status_ff == ST_OK) && (kind_ff == CMD_ALLOC)) begin
            rsp_ff.block_address <= {1'b0, cfg.base} + (33'(pos_ff) << cfg.shift);
         end else begin
            rsp_ff.block_address <= '0;
         end
         rsp_ff.largest_free_bytes <= 31'(largest_ff) << cfg.shift;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> design/bfpa_checker.sv
// ----------------------------------------------------------------------------
// bfpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input bfpa_pkg::rsp_type rsp_item
);
   import bfpa_pkg::*;

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // only a successful allocate carries an address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.status != ST_OK)) |-> (rsp_item.block_address == 33'd0))
      else $error("address on failed item");

endmodule

bind best_fit_page_bitmap_allocator bfpa_checker u_bfpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);

>>> dv/best_fit_page_bitmap_allocator_test.sv
// ----------------------------------------------------------------------------
// best_fit_page_bitmap_allocator_test
// Self-checking regression: a bitmap predictor tracks every request and each
// result is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module best_fit_page_bitmap_allocator_test;
   import bfpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_item;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   best_fit_page_bitmap_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [NUM_PAGES-1:0] used_pages;
   logic [31:0] cur_base;
   logic [4:0]  cur_shift;
   logic [10:0] cur_count;

   rsp_type expected_rsps[$];
   int  n_errors;
   int  n_results;
   int  n_allocs_ok;
   int  n_frees_ok;
   int  n_bad;
   bit  no_idle;

   // the bench's own record of live blocks, used to build sensible frees
   logic [31:0] live_addr[$];
   logic [30:0] live_len[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("best_fit_page_bitmap_allocator regression: fail");
      $finish;
   end

   function automatic bit page_free(int p);
      int lim;
      lim = (cur_count > NUM_PAGES) ? NUM_PAGES : cur_count;
      if (p >= lim) return 1'b0;
      return !used_pages[p];
   endfunction

   // longest free run and best-fit start for need pages
   function automatic int run_scan(longint need, output bit found, output int pos);
      int largest, run, start;
      longint best_left, left;
      largest = 0; run = 0; start = 0; best_left = 64'h7FFF_FFFF_FFFF_FFFF;
      found = 1'b0; pos = 0;
      for (int p = 0; p <= NUM_PAGES; p++) begin
         if (page_free(p)) begin
            if (run == 0) start = p;
            run++;
         end else if (run != 0) begin
            if (run > largest) largest = run;
            if (need != 0 && run >= need) begin
               left = run - need;
               if (left < best_left) begin
                  best_left = left; found = 1'b1; pos = start;
               end
            end
            run = 0;
         end
      end
      return largest;
   endfunction

   function automatic rsp_type predict_request(req_type rq);
      rsp_type r;
      int sh, pos, lim, largest;
      bit found;
      longint pages, first, lb;
      sh = (cur_shift > MAX_SHIFT) ? MAX_SHIFT : cur_shift;
      lim = (cur_count > NUM_PAGES) ? NUM_PAGES : cur_count;
      pages = (longint'(rq.length_bytes) + ((64'd1 << sh) - 1)) >> sh;
      r.status = ST_OK;
      r.block_address = '0;
      if (rq.length_bytes == 0) begin
         r.status = ST_ZERO;
      end else if (rq.action == ACT_ALLOC) begin
         void'(run_scan(pages, found, pos));
         if (!found) begin
            r.status = ST_NOFIT;
         end else begin
            for (longint i = 0; i < pages; i++)
               if (pos + i < NUM_PAGES) used_pages[pos + i] = 1'b1;
            r.block_address = {1'b0, cur_base} + (33'(pos) << sh);
         end
      end else if (rq.address < cur_base) begin
         r.status = ST_RANGE;
      end else begin
         first = longint'(rq.address - cur_base) >> sh;
         if (first + pages > lim) begin
            r.status = ST_RANGE;
         end else begin
            for (longint i = 0; i < pages; i++) used_pages[first + i] = 1'b0;
         end
      end
      largest = run_scan(0, found, pos);
      lb = longint'(largest) << sh;
      r.largest_free_bytes = (lb > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : lb[30:0];
      return r;
   endfunction

   // push stays high between back-to-back items and drops while idling, draining or paused
   task automatic idle_gap();
      if (!no_idle && ($urandom_range(99) < 33)) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 33);
      end
   endtask

   task automatic send_request(logic act, logic [31:0] addr, logic [30:0] len);
      req_type rq;
      rsp_type r;
      rq.action = act; rq.address = addr; rq.length_bytes = len;
      idle_gap();
      req_push <= 1'b1;
      req_item <= rq;
      do @(posedge clock); while (req_full);
      r = predict_request(rq);
      expected_rsps.push_back(r);
      if (r.status == ST_OK && act == ACT_ALLOC) begin
         n_allocs_ok++;
         live_addr.push_back(r.block_address[31:0]);
         live_len.push_back(len);
      end else if (r.status == ST_OK) begin
         n_frees_ok++;
      end else begin
         n_bad++;
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASE:  cur_base  = val;
         CSR_SHIFT: cur_shift = val[4:0];
         CSR_COUNT: cur_count = val[10:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] b, logic [31:0] s, logic [31:0] c);
      drain_results();
      write_register(CSR_BASE, b);
      write_register(CSR_SHIFT, s);
      write_register(CSR_COUNT, c);
      csr_valid <= 1'b0;
   endtask

   // picks a live block (or a random address) and frees it
   task automatic free_random();
      int k;
      if (live_addr.size() != 0 && $urandom_range(9) < 8) begin
         k = $urandom_range(live_addr.size() - 1);
         send_request(ACT_FREE, live_addr[k], live_len[k]);
         live_addr.delete(k);
         live_len.delete(k);
      end else begin
         send_request(ACT_FREE, $urandom, 31'($urandom_range(1, 1 << 14)));
      end
   endtask

   task automatic test_directed();
      // default configuration after reset
      send_request(ACT_ALLOC, 32'h0, 31'd0);
      send_request(ACT_FREE, 32'hFFFF_FFFF, 31'd0);
      send_request(ACT_ALLOC, 32'hFFFF_FFFF, 31'd1);
      send_request(ACT_ALLOC, 32'h0, 31'd4096);
      send_request(ACT_ALLOC, 32'h0, 31'd4097);
      send_request(ACT_ALLOC, 32'h0, 31'h4000_0000);
      send_request(ACT_FREE, 32'h0, 31'd4096);
      send_request(ACT_ALLOC, 32'h0, 31'd4096);
      send_request(ACT_FREE, 32'h0, 31'h7FFF_FFFF);
      send_request(ACT_FREE, 32'h0, 31'd4194304);
      send_request(ACT_FREE, 32'h0, 31'd4194304);
      live_addr.delete(); live_len.delete();
      // the largest run at the largest page size, and an offset base
      set_config(32'hFFFF_F000, 32'd20, 32'd1024);
      send_request(ACT_ALLOC, 32'h0, 31'd1);
      send_request(ACT_FREE, 32'h0, 31'd1);
      send_request(ACT_FREE, 32'hFFFF_F000, 31'd1);
      send_request(ACT_FREE, 32'hFFFF_FFFF, 31'h4000_0000);
      // shift above twenty, page count above the array, page count zero and one
      set_config(32'h1000, 32'd31, 32'd2047);
      send_request(ACT_ALLOC, 32'h0, 31'd1 << 21);
      send_request(ACT_FREE, 32'h1000, 31'd1 << 21);
      set_config(32'h1000, 32'd0, 32'd0);
      send_request(ACT_ALLOC, 32'h0, 31'd1);
      send_request(ACT_FREE, 32'h1000, 31'd1);
      set_config(32'h0, 32'd0, 32'd1);
      send_request(ACT_ALLOC, 32'h0, 31'd1);
      send_request(ACT_ALLOC, 32'h0, 31'd1);
      send_request(ACT_FREE, 32'h0, 31'd1);
   endtask

   // small pages so runs fragment and best fit is exercised
   task automatic test_fragmented_mix(int n_items, int count);
      set_config($urandom, 32'($urandom_range(0, 3)), 32'(count));
      live_addr.delete(); live_len.delete();
      send_request(ACT_FREE, cur_base, 31'(count) << cur_shift);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 55)
            send_request(ACT_ALLOC, $urandom,
                         (31'($urandom_range(1, 12)) << cur_shift)
                         - 31'($urandom_range(0, 1)));
         else
            free_random();
      end
   endtask

   task automatic test_random_noise(int n_items);
      set_config($urandom, 32'($urandom_range(0, 31)), 32'($urandom_range(0, 2047)));
      live_addr.delete(); live_len.delete();
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(3))
            0: send_request(ACT_ALLOC, $urandom, 31'($urandom));
            1: send_request(ACT_ALLOC, $urandom, 31'($urandom_range(0, 1 << 16)));
            2: send_request(ACT_FREE, $urandom, 31'($urandom));
            default: free_random();
         endcase
      end
   endtask

   // hold the sender until every outstanding result has come back
   task automatic test_sender_pause();
      send_request(ACT_ALLOC, 32'h0, 31'd5);
      send_request(ACT_ALLOC, 32'h0, 31'd3);
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      send_request(ACT_ALLOC, 32'h0, 31'd2);
   endtask

   // result checker and receiver-side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            n_results++;
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected");
               n_errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_item.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_item.status);
                  n_errors++;
               end
               if (rsp_item.block_address !== e.block_address) begin
                  $error("block_address: expected %h actual %h",
                         e.block_address, rsp_item.block_address);
                  n_errors++;
               end
               if (rsp_item.largest_free_bytes !== e.largest_free_bytes) begin
                  $error("largest_free_bytes: expected %h actual %h",
                         e.largest_free_bytes, rsp_item.largest_free_bytes);
                  n_errors++;
               end
            end
         end
         rsp_pop <= no_idle || ($urandom_range(99) >= 33);
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0; req_item = '0;
      csr_valid = 1'b0; csr_index = CSR_BASE; csr_data = '0;
      used_pages = '0; cur_base = '0; cur_shift = 5'd12; cur_count = 11'd1024;
      n_errors = 0; n_results = 0; n_allocs_ok = 0; n_frees_ok = 0; n_bad = 0;
      no_idle = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_sender_pause();
      test_fragmented_mix(300, 1024);
      test_fragmented_mix(250, 40);
      no_idle = 1'b1;
      test_fragmented_mix(150, $urandom_range(1, 200));
      no_idle = 1'b0;
      test_random_noise(150);
      test_fragmented_mix(250, $urandom_range(100, 1024));
      drain_results();
      repeat (500) @(posedge clock);

      $display("covered %0d results: %0d good allocates, %0d good frees, %0d error items",
               n_results, n_allocs_ok, n_frees_ok, n_bad);
      $display("configurations swept across base, page size and page count extremes");
      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("best_fit_page_bitmap_allocator regression: pass");
      else
         $display("best_fit_page_bitmap_allocator regression: fail");
      $finish;
   end

endmodule
